@@ rtl/sliding_window_median_core_macros.svh @@
// Assertion macros for the sliding window median core.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked outside reset only
`define SWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SWM_ASSERT(lbl, prop, msg)
`define SWM_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ rtl/swm_pkg.sv @@
package swm_pkg;

  localparam int CfgWidth  = 7;
  localparam int PortWidth = 32;
  localparam int OutWidth  = PortWidth + 1;

  // what a cell tells its neighbours about itself
  typedef struct packed {
    logic shift;  // the deleted entry sits at or below this cell
    logic le;     // entry held and not above the new sample
  } swm_flags_t;

endpackage

@@ rtl/swm_cell.sv @@
module swm_cell #(
  parameter int SW = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                del_en_i,
  input  logic                valid_i,
  input  logic [SW-1:0]       sample_i,
  input  logic [SW-1:0]       old_i,
  input  logic [SW-1:0]       left_val_i,
  input  swm_pkg::swm_flags_t left_flags_i,
  input  logic [SW-1:0]       right_val_i,
  input  swm_pkg::swm_flags_t right_flags_i,
  output logic [SW-1:0]       val_o,
  output swm_pkg::swm_flags_t flags_o
);
  import swm_pkg::*;

  logic [SW-1:0] val_q, val_d;
  logic [SW-1:0] after_del;
  logic [SW-1:0] left_after_del;
  logic          le_after_del;
  logic          left_le_after_del;
  swm_flags_t    flags;

  always_comb begin
    // the leftmost copy of the leaving value is removed, so every cell at or
    // above it moves down by one
    flags.shift = del_en_i && valid_i && ($signed(val_q) >= $signed(old_i));
    flags.le    = valid_i && ($signed(val_q) <= $signed(sample_i));
  end

  always_comb begin
    after_del         = flags.shift ? right_val_i : val_q;
    le_after_del      = flags.shift ? right_flags_i.le : flags.le;
    left_after_del    = left_flags_i.shift ? val_q : left_val_i;
    left_le_after_del = left_flags_i.shift ? flags.le : left_flags_i.le;
    if (le_after_del) begin
      val_d = after_del;
    end else if (left_le_after_del) begin
      val_d = sample_i;
    end else begin
      val_d = left_after_del;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o   = val_q;
  assign flags_o = flags;

endmodule

@@ rtl/swm_ring.sv @@
module swm_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
      // read rides on the write; same slot returns the new item
      if (raddr_i == waddr_i) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/sliding_window_median_core.sv @@
// Sliding window median: the item that completes the window sets the pending stage,
// whose median moves into the output register when free. Throughput one item per
// cycle unless a pending result meets a stalled output; the sorted cell row takes each
// item and the oldest sample is fetched ahead from the arrival ring, one read per item.
// Reset (async, active low) empties the window and sets the window size to 1.
// Output stall holds the result; items go on being taken until a second result waits.
`include "sliding_window_median_core_macros.svh"

module sliding_window_median_core #(
  parameter int WINDOW_MAX   = 64,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swm_pkg::CfgWidth-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swm_pkg::PortWidth-1:0] sample_i,
  input  logic                                last_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swm_pkg::OutWidth-1:0] median_doubled_o,
  output logic                                last_median_o
);
  import swm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int WW = $clog2(WINDOW_MAX + 1);
  localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CfgWidth-1:0] win_q;
  logic [WW-1:0]       fill_q, fill_d;
  logic [PW-1:0]       pos_q, pos_d;
  logic [WW-1:0]       w_eff;
  logic [WW-1:0]       pos_plus;
  logic [PW-1:0]       pos_next;
  logic [WW-1:0]       fill_keep;
  logic [WW-1:0]       fill_inc;
  logic                del_en;
  logic                produce;
  logic                accept;
  logic                o_free;
  logic                move_out;
  logic [SW-1:0]       new_sample;
  logic [SW-1:0]       old_sample;

  logic                p1_valid_q, p1_valid_d;
  logic                p1_last_q;
  logic                out_valid_q, out_valid_d;
  logic [OutWidth-1:0] median_q;
  logic                last_q;

  logic [SW-1:0]       cell_val   [WINDOW_MAX];
  swm_flags_t          cell_flags [WINDOW_MAX];

  logic [PW-1:0]       med_hi, med_lo;
  logic [SW:0]         med_sum;

  assign cfg_ready_o = 1'b1;
  assign new_sample  = sample_i[SW-1:0];

  always_comb begin
    if (win_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(win_q) > 32'(WINDOW_MAX)) begin
      w_eff = WW'(WINDOW_MAX);
    end else begin
      w_eff = WW'(win_q);
    end
  end

  always_comb begin
    pos_plus  = WW'(pos_q) + WW'(1);
    pos_next  = (pos_plus == w_eff) ? '0 : PW'(pos_plus);
    del_en    = fill_q >= w_eff;
    fill_keep = del_en ? (w_eff - WW'(1)) : fill_q;
    fill_inc  = fill_keep + WW'(1);
    produce   = fill_inc == w_eff;
  end

  assign o_free     = !out_valid_q || !out_stall_i;
  assign move_out   = p1_valid_q && o_free;
  assign in_stall_o = p1_valid_q && !o_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    fill_d = fill_q;
    pos_d  = pos_q;
    if (cfg_valid_i && cfg_ready_o) begin
      fill_d = '0;
      pos_d  = '0;
    end else if (accept) begin
      if (last_sample_i) begin
        fill_d = '0;
        pos_d  = '0;
      end else begin
        fill_d = fill_inc;
        pos_d  = pos_next;
      end
    end
  end

  always_comb begin
    p1_valid_d = p1_valid_q;
    if (accept && produce) begin
      p1_valid_d = 1'b1;
    end else if (move_out) begin
      p1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CfgWidth'(1);
      fill_q      <= '0;
      pos_q       <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      p1_valid_q  <= p1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // oldest sample for the next item is read one item ahead
  swm_ring #(
    .DEPTH (WINDOW_MAX),
    .AW    (PW),
    .DW    (SW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (pos_q),
    .wdata_i (new_sample),
    .raddr_i (pos_next),
    .rdata_o (old_sample)
  );

  for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
    logic [SW-1:0] left_val;
    logic [SW-1:0] right_val;
    swm_flags_t    left_flags;
    swm_flags_t    right_flags;
    logic          cell_valid;

    assign cell_valid = WW'(j) < fill_q;

    if (j == 0) begin : g_first
      assign left_val   = '0;
      assign left_flags = '{shift: 1'b0, le: 1'b1};
    end else begin : g_mid_l
      assign left_val   = cell_val[j-1];
      assign left_flags = cell_flags[j-1];
    end

    if (j == WINDOW_MAX - 1) begin : g_last
      assign right_val   = '0;
      assign right_flags = '{shift: 1'b0, le: 1'b0};
    end else begin : g_mid_r
      assign right_val   = cell_val[j+1];
      assign right_flags = cell_flags[j+1];
    end

    swm_cell #(
      .SW (SW)
    ) u_cell (
      .clk_i         (clk_i),
      .en_i          (accept),
      .del_en_i      (del_en),
      .valid_i       (cell_valid),
      .sample_i      (new_sample),
      .old_i         (old_sample),
      .left_val_i    (left_val),
      .left_flags_i  (left_flags),
      .right_val_i   (right_val),
      .right_flags_i (right_flags),
      .val_o         (cell_val[j]),
      .flags_o       (cell_flags[j])
    );
  end

  // middle taps follow the window size
  always_comb begin
    med_hi  = PW'(w_eff >> 1);
    med_lo  = w_eff[0] ? med_hi : (med_hi - PW'(1));
    med_sum = {cell_val[med_lo][SW-1], cell_val[med_lo]}
            + {cell_val[med_hi][SW-1], cell_val[med_hi]};
  end

  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      p1_last_q <= last_sample_i;
    end
    if (move_out) begin
      median_q <= OutWidth'($signed(med_sum));
      last_q   <= p1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = median_q;
  assign last_median_o    = last_q;

  `SWM_ASSERT(a_fill_bound, fill_q <= w_eff, "fill count above window size")
  `SWM_ASSERT(a_pos_bound, WW'(pos_q) < w_eff, "ring position outside window")
  `SWM_ASSERT(a_pending_full, (p1_valid_q && !p1_last_q) |-> (fill_q == w_eff), "window not full")

endmodule
